// ===== design/sppd_pkg.sv =====
// Shared types, constants and helpers for the stereo ping-pong delay.
// No dependencies; imported by sppd_ctrl, sppd_dpath and stereo_ping_pong_delay.
package sppd_pkg;

    // Delay line geometry
    localparam int LINE_DEPTH = 65536;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int POS_W      = ADDR_W + 8;                 // line position, Q.8
    localparam int D_W        = (POS_W > 24) ? POS_W : 24;  // clamped delay width

    localparam logic [D_W-1:0] DLY_MIN = D_W'(256);
    localparam logic [D_W-1:0] DLY_MAX = D_W'((LINE_DEPTH - 2) * 256);

    // Sample and gain formats
    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    localparam logic [15:0] FB_MAX = 16'd55705;
    localparam logic [16:0] UNITY  = 17'd65536;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_DELAY  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FB     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MIX    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BYPASS = 3'd3;
    localparam logic [IDX_W-1:0] CFG_STEP   = 3'd4;

    // Register reset values
    localparam logic [23:0] DELAY_RST = 24'd6144000;
    localparam logic [15:0] FB_RST    = 16'd19661;
    localparam logic [16:0] MIX_RST   = 17'd16384;
    localparam logic        BYP_RST   = 1'b0;
    localparam logic [16:0] STEP_RST  = 17'd137;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture dry pair, read both taps
        logic interp;   // interpolate the taps
        logic mix;      // feedback write, dry/wet mix, ramp update
        logic blend;    // blend into output register
    } t_cmd;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [31:0] x);
        logic signed [SAMPLE_W-1:0] y;
        if (x > 32'sd8388607) begin
            y = 24'sh7FFFFF;
        end else if (x < -32'sd8388608) begin
            y = 24'sh800000;
        end else begin
            y = x[SAMPLE_W-1:0];
        end
        return y;
    endfunction

    function automatic logic [D_W-1:0] clamp_delay(input logic [23:0] v);
        logic [D_W-1:0] x;
        x = D_W'(v);
        if (x < DLY_MIN) begin
            x = DLY_MIN;
        end else if (x > DLY_MAX) begin
            x = DLY_MAX;
        end
        return x;
    endfunction

endpackage

// ===== design/sppd_ctrl.sv =====
// Sequencer for the stereo ping-pong delay: handshakes and step commands.
// Depends on sppd_pkg.
module sppd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          i_cfg_we,
    output sppd_pkg::t_cmd o_cmd
);
    import sppd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INTERP,
        S_MIX,
        S_BLEND
    } t_state;

    t_state r_state;
    logic   r_ov;       // output register holds a result
    logic   r_stale;    // read address register not yet refreshed

    logic in_xfer;
    logic out_load;

    assign o_in_ready  = (r_state == S_IDLE) && !r_stale;
    assign in_xfer     = o_in_ready && i_in_valid;
    assign out_load    = (r_state == S_BLEND) && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;

    assign o_cmd.accept = in_xfer;
    assign o_cmd.interp = (r_state == S_INTERP);
    assign o_cmd.mix    = (r_state == S_MIX);
    assign o_cmd.blend  = out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_stale <= 1'b1;
        end else begin
            r_stale <= i_cfg_we;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) r_state <= S_INTERP;
                end
                S_INTERP: r_state <= S_MIX;
                S_MIX:    r_state <= S_BLEND;
                S_BLEND: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // read address must be refreshed after a delay change before a transfer
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("input ready right after a config write");
    // a transfer reaches the line write after the interpolate step
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##2 o_cmd.mix)
        else $error("step sequence broken");
    // never overwrite a result that is still waiting
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.blend |-> (!r_ov || i_out_ready))
        else $error("pending result overwritten");
    // no new item while one is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mix |-> !o_in_ready)
        else $error("input ready during processing");
`endif

endmodule

// ===== design/sppd_dpath.sv =====
// Datapath for the stereo ping-pong delay: config registers, line memories,
// interpolation, feedback, mix and blend arithmetic. Depends on sppd_pkg.
module sppd_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sppd_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [sppd_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [sppd_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic signed [sppd_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [sppd_pkg::SAMPLE_W-1:0] i_right_in,
    output logic signed [sppd_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sppd_pkg::SAMPLE_W-1:0] o_right_out
);
    import sppd_pkg::*;

    localparam int A_W = D_W + 1;
    localparam logic [A_W-1:0] LINE_SPAN = A_W'(LINE_DEPTH * 256);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);

    // config
    logic [D_W-1:0] r_dly;
    logic [15:0]    r_fb;
    logic [16:0]    r_mix;
    logic           r_byp;
    logic [16:0]    r_step;

    // state
    logic [ADDR_W-1:0] r_wp;
    logic              r_wrap;     // every entry written at least once
    logic [16:0]       r_wa;

    logic signed [SAMPLE_W-1:0] r_line_l [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_line_r [LINE_DEPTH];

    // read address, refreshed every cycle
    logic [ADDR_W-1:0] r_first;
    logic [7:0]        r_frac;

    // per-item working registers
    logic signed [SAMPLE_W-1:0] r_dry_l, r_dry_r;
    logic signed [SAMPLE_W-1:0] r_a_l, r_b_l, r_a_r, r_b_r;
    logic                       r_va, r_vb;
    logic [7:0]                 r_fr;
    logic signed [SAMPLE_W-1:0] r_wet_l, r_wet_r;
    logic signed [24:0]         r_mt_l, r_mt_r;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r;

    // ---------------- config writes ----------------
    logic [16:0] wd17;
    assign wd17 = i_cfg_wdata[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly  <= clamp_delay(DELAY_RST);
            r_fb   <= FB_RST;
            r_mix  <= MIX_RST;
            r_byp  <= BYP_RST;
            r_step <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY:  r_dly  <= clamp_delay(i_cfg_wdata[23:0]);
                CFG_FB:     r_fb   <= (i_cfg_wdata[15:0] > FB_MAX) ? FB_MAX
                                                                   : i_cfg_wdata[15:0];
                CFG_MIX:    r_mix  <= (wd17 > UNITY) ? UNITY : wd17;
                CFG_BYPASS: r_byp  <= i_cfg_wdata[0];
                CFG_STEP:   r_step <= (wd17 == 17'd0) ? 17'd1
                                    : ((wd17 > UNITY) ? UNITY : wd17);
                default: ;
            endcase
        end
    end

    // ---------------- read address ----------------
    logic [A_W-1:0] pos_base, pos_sub, pos;
    assign pos_base = A_W'({r_wp, 8'd0});
    assign pos_sub  = pos_base - A_W'(r_dly);
    assign pos      = pos_sub[A_W-1] ? (pos_sub + LINE_SPAN) : pos_sub;

    always_ff @(posedge i_clk) begin
        r_first <= pos[POS_W-1:8];
        r_frac  <= pos[7:0];
    end

    logic [ADDR_W-1:0] second;
    assign second = (r_first == LAST_ADDR) ? '0 : (r_first + 1'b1);

    // ---------------- line memories ----------------
    logic signed [SAMPLE_W-1:0] n_line_l, n_line_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_l <= r_line_l[r_first];
            r_b_l <= r_line_l[second];
        end
        if (i_cmd.mix) begin
            r_line_l[r_wp] <= n_line_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_r <= r_line_r[r_first];
            r_b_r <= r_line_r[second];
        end
        if (i_cmd.mix) begin
            r_line_r[r_wp] <= n_line_r;
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dry_l <= i_left_in;
            r_dry_r <= i_right_in;
            r_va    <= r_wrap || (r_first < r_wp);
            r_vb    <= r_wrap || (second < r_wp);
            r_fr    <= r_frac;
        end
    end

    // ---------------- interpolation ----------------
    logic signed [SAMPLE_W-1:0] a_l, b_l, a_r, b_r;
    logic signed [24:0]         df_l, df_r;
    logic signed [33:0]         ip_l, ip_r, ir_l, ir_r;
    logic [25:0]                wet26_l, wet26_r;

    always_comb begin
        a_l = r_va ? r_a_l : '0;
        b_l = r_vb ? r_b_l : '0;
        a_r = r_va ? r_a_r : '0;
        b_r = r_vb ? r_b_r : '0;
        df_l = {b_l[23], b_l} - {a_l[23], a_l};
        df_r = {b_r[23], b_r} - {a_r[23], a_r};
        ip_l = $signed({1'b0, r_fr}) * df_l;
        ip_r = $signed({1'b0, r_fr}) * df_r;
        ir_l = ip_l + 34'sd128;
        ir_r = ip_r + 34'sd128;
        wet26_l = {{2{a_l[23]}}, a_l} + ir_l[33:8];
        wet26_r = {{2{a_r[23]}}, a_r} + ir_r[33:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp) begin
            r_wet_l <= wet26_l[23:0];
            r_wet_r <= wet26_r[23:0];
        end
    end

    // ---------------- feedback, mix, ramp ----------------
    logic signed [40:0] fp_l, fp_r, fr_l, fr_r;
    logic signed [25:0] fs_l, fs_r;
    logic signed [24:0] md_l, md_r;
    logic signed [42:0] mp_l, mp_r, mr_l, mr_r;
    logic signed [17:0] tgt, dif, stp;
    logic [17:0]        n_wa18;

    always_comb begin
        // cross feedback: right wet into left line and vice versa
        fp_l = r_wet_r * $signed({1'b0, r_fb});
        fp_r = r_wet_l * $signed({1'b0, r_fb});
        fr_l = fp_l + 41'sd32768;
        fr_r = fp_r + 41'sd32768;
        fs_l = {{2{r_dry_l[23]}}, r_dry_l} + {fr_l[40], fr_l[40:16]};
        fs_r = {{2{r_dry_r[23]}}, r_dry_r} + {fr_r[40], fr_r[40:16]};
        n_line_l = sat24(32'(fs_l));
        n_line_r = sat24(32'(fs_r));

        md_l = {r_wet_l[23], r_wet_l} - {r_dry_l[23], r_dry_l};
        md_r = {r_wet_r[23], r_wet_r} - {r_dry_r[23], r_dry_r};
        mp_l = $signed({1'b0, r_mix}) * md_l;
        mp_r = $signed({1'b0, r_mix}) * md_r;
        mr_l = mp_l + 43'sd32768;
        mr_r = mp_r + 43'sd32768;

        tgt = r_byp ? 18'sd0 : $signed({1'b0, UNITY});
        stp = $signed({1'b0, r_step});
        dif = tgt - $signed({1'b0, r_wa});
        if (dif > stp) begin
            dif = stp;
        end else if (dif < -stp) begin
            dif = -stp;
        end
        n_wa18 = {1'b0, r_wa} + dif;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_mt_l <= mr_l[40:16];
            r_mt_r <= mr_r[40:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wrap <= 1'b0;
            r_wa   <= '0;
        end else if (i_cmd.mix) begin
            r_wa <= n_wa18[16:0];
            if (r_wp == LAST_ADDR) begin
                r_wp   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // ---------------- blend ----------------
    logic signed [42:0] bp_l, bp_r, br_l, br_r;
    logic signed [27:0] bs_l, bs_r;

    always_comb begin
        bp_l = $signed({1'b0, r_wa}) * r_mt_l;
        bp_r = $signed({1'b0, r_wa}) * r_mt_r;
        br_l = bp_l + 43'sd32768;
        br_r = bp_r + 43'sd32768;
        bs_l = {{4{r_dry_l[23]}}, r_dry_l} + {br_l[42], br_l[42:16]};
        bs_r = {{4{r_dry_r[23]}}, r_dry_r} + {br_r[42], br_r[42:16]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend) begin
            r_out_l <= sat24(32'(bs_l));
            r_out_r <= sat24(32'(bs_r));
        end
    end

    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

`ifndef NO_ASSERTIONS
    // ramp never leaves the unit range
    a_wa_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wa <= UNITY)
        else $error("wet amount above unity");
    // write position only moves on a line write
    a_wp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.mix |=> $stable(r_wp))
        else $error("write position moved without a line write");
`endif

endmodule

// ===== design/stereo_ping_pong_delay.sv =====
// Top level of the stereo ping-pong delay: sequencer plus datapath.
// Depends on sppd_pkg, sppd_ctrl and sppd_dpath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready    | i_left_in, i_right_in (Q5.18)
//  output   | o_out_valid / i_out_ready  | o_left_out, o_right_out (Q5.18)
//  config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// Each item goes through these steps in order: the transfer cycle reads both
// taps of each line memory, then interpolation, then feedback write plus
// dry/wet mix, then the blend into the output register. A config write holds
// off the next input transfer while the read address register refreshes.
// Reset is synchronous, active low; line contents read as zero until written.
// The blend step waits while the output register holds an untaken result.
module stereo_ping_pong_delay (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sppd_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [sppd_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sppd_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sppd_pkg::SAMPLE_W-1:0] o_right_out,
    input  logic                                i_cfg_we,
    input  logic [sppd_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [sppd_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import sppd_pkg::*;

    t_cmd cmd;  // step commands, sequencer to datapath

    // Sequencer: owns both handshakes and steps each transfer through
    // interpolate, mix/write and blend.
    sppd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .o_cmd       (cmd)
    );

    // Datapath: config registers, both delay lines, and the arithmetic.
    sppd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for stereo_ping_pong_delay: stereo pairs in, processed pairs out.
// Depends on sppd_pkg and the stereo_ping_pong_delay RTL; carries its own delay line predictor.
`timescale 1ns / 100ps

module tb;
    import sppd_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo;

    // DUT ports; every input starts at a known value
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_left_in   = '0;
    logic signed [SAMPLE_W-1:0] i_right_in  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic                       i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]           i_cfg_idx   = '0;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;

    stereo_ping_pong_delay u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of both lines, pointer, ramp, registers
    // ------------------------------------------------------------------
    int          echo_l [LINE_DEPTH];
    int          echo_r [LINE_DEPTH];
    int          wr_ptr;
    longint      ramp_gain;      // Q16 wet amount, 0 .. 65536
    logic [23:0] dly_reg;
    logic [15:0] fb_reg;
    logic [16:0] mix_reg;
    logic        byp_reg;
    logic [16:0] step_reg;

    // Testbench bookkeeping
    t_stereo dry_q[$];           // pairs waiting for the driver
    t_stereo expected_out_q[$];  // predicted outputs, oldest first
    int      queued_cnt   = 0;
    int      issued_cnt   = 0;
    int      accepted_cnt = 0;
    int      out_cnt      = 0;
    int      mismatch_cnt = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;

    function automatic void clear_model();
        for (int k = 0; k < LINE_DEPTH; k++) begin
            echo_l[k] = 0;
            echo_r[k] = 0;
        end
        wr_ptr    = 0;
        ramp_gain = 0;
        dly_reg   = DELAY_RST;
        fb_reg    = FB_RST;
        mix_reg   = MIX_RST;
        byp_reg   = BYP_RST;
        step_reg  = STEP_RST;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DELAY:  dly_reg  = data[23:0];
            CFG_FB:     fb_reg   = data[15:0];
            CFG_MIX:    mix_reg  = data[16:0];
            CFG_BYPASS: byp_reg  = data[0];
            CFG_STEP:   step_reg = data[16:0];
            default: ;  // no register behind this index
        endcase
    endfunction

    // x / 2^n rounded to nearest, ties toward +inf (>>> floors on signed longint)
    function automatic longint round_q(input longint x, input int n);
        longint b;
        b = x + (longint'(1) << (n - 1));
        return b >>> n;
    endfunction

    function automatic longint clip24(input longint x);
        if (x > longint'(S_MAX)) return longint'(S_MAX);
        if (x < longint'(S_MIN)) return longint'(S_MIN);
        return x;
    endfunction

    // Linear interpolation between two neighboring line entries, pos in Q.8
    function automatic longint tap_read(input bit right_side, input longint pos);
        int     first;
        int     second;
        longint frac;
        longint a;
        longint b;
        first  = int'((pos >> 8) % LINE_DEPTH);
        second = (first + 1) % LINE_DEPTH;
        frac   = pos & 255;
        a = right_side ? echo_r[first]  : echo_l[first];
        b = right_side ? echo_r[second] : echo_l[second];
        return a + round_q(frac * (b - a), 8);
    endfunction

    // One sample period of the effect: read taps, cross-feed lines, mix, ramp, blend
    function automatic t_stereo process_pair(input t_stereo dry);
        longint  dl;
        longint  dr;
        longint  dly;
        longint  fb;
        longint  mixg;
        longint  stp;
        longint  pos;
        longint  wl;
        longint  wr;
        longint  ml;
        longint  mr;
        longint  goal;
        longint  delta;
        longint  ol;
        longint  orr;
        t_stereo res;
        dl = longint'($signed(dry.left));
        dr = longint'($signed(dry.right));

        // out-of-range settings saturate rather than wrap
        dly = longint'(dly_reg);
        if (dly < 256) dly = 256;
        if (dly > longint'(LINE_DEPTH - 2) * 256) dly = longint'(LINE_DEPTH - 2) * 256;
        fb   = (fb_reg > FB_MAX) ? longint'(FB_MAX) : longint'(fb_reg);
        mixg = (mix_reg > UNITY) ? longint'(UNITY) : longint'(mix_reg);
        if (step_reg == 0) begin
            stp = 1;
        end else begin
            stp = (step_reg > UNITY) ? longint'(UNITY) : longint'(step_reg);
        end

        // read position trails the write pointer; one wrap at most
        pos = longint'(wr_ptr) * 256;
        if (pos < dly) pos += longint'(LINE_DEPTH) * 256;
        pos -= dly;
        wl = tap_read(1'b0, pos);
        wr = tap_read(1'b1, pos);

        // ping-pong: each line takes the other side's echo
        echo_l[wr_ptr] = int'(clip24(dl + round_q(wr * fb, 16)));
        echo_r[wr_ptr] = int'(clip24(dr + round_q(wl * fb, 16)));

        ml = dl + round_q(mixg * (wl - dl), 16);
        mr = dr + round_q(mixg * (wr - dr), 16);

        goal  = byp_reg ? 0 : longint'(UNITY);
        delta = goal - ramp_gain;
        if (delta > stp)  delta = stp;
        if (delta < -stp) delta = -stp;
        ramp_gain += delta;

        ol  = clip24(dl + round_q(ramp_gain * (ml - dl), 16));
        orr = clip24(dr + round_q(ramp_gain * (mr - dr), 16));
        res.left  = ol[23:0];
        res.right = orr[23:0];

        wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: output %0d %s: got %0d, want %0d", $time, out_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: launches pairs at the falling edge, holds until transfer
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // free when nothing is offered or the offered pair was taken
            if (!i_in_valid || accepted_cnt == issued_cnt) begin
                if (dry_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_left_in  <= dry_q[0].left;
                    i_right_in <= dry_q[0].right;
                    void'(dry_q.pop_front());
                    issued_cnt++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check output transfers, then predict for input transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_out_q.size() == 0) begin
                    report_mismatch("arrived with nothing pending", o_left_out, 0);
                end else begin
                    if (o_left_out !== expected_out_q[0].left) begin
                        report_mismatch("left_out", o_left_out, expected_out_q[0].left);
                    end
                    if (o_right_out !== expected_out_q[0].right) begin
                        report_mismatch("right_out", o_right_out, expected_out_q[0].right);
                    end
                    void'(expected_out_q.pop_front());
                end
                out_cnt++;
            end
            if (i_in_valid && o_in_ready) begin
                expected_out_q.push_back(process_pair({i_left_in, i_right_in}));
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_dry(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
        dry_q.push_back({l, r});
        queued_cnt++;
    endtask

    // Block is idle once every pair was taken and every output came back;
    // the short pause lets the last result fully retire.
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_out_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        apply_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int sel;
        int small_v;
        sel = $urandom_range(0, 99);
        small_v = int'($urandom_range(0, 131071)) - 65536;
        if (sel < 60) return SAMPLE_W'($urandom);
        if (sel < 85) return SAMPLE_W'(small_v);
        if (sel < 92) return S_MAX;
        if (sel < 99) return S_MIN;
        return '0;
    endfunction

    // Per-phase settings: the early phases hit the register extremes and the
    // saturating cases, later ones draw mostly short delays so echoes recirculate.
    task automatic random_phase(input int p);
        logic [CFG_W-1:0] dly_v;
        logic [CFG_W-1:0] fb_v;
        logic [CFG_W-1:0] mix_v;
        logic [CFG_W-1:0] step_v;
        wait_idle();
        if (p < 3) begin
            send_gap_pct = 28;
            recv_stall_pct = 68;
        end else if (p < 6) begin
            send_gap_pct = 68;
            recv_stall_pct = 28;
        end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
        end

        case (p)
            0: dly_v = 24'd0;                    // below one sample
            1: dly_v = 24'hFFFFFF;               // above the line length
            2: dly_v = 24'd16776704;             // longest legal delay
            3: dly_v = 24'd384;                  // one and a half samples
            8: dly_v = CFG_W'($urandom);
            default: dly_v = CFG_W'($urandom_range(256, 256 * 48));
        endcase
        case (p)
            0, 3, 6: fb_v = 24'd55705;
            1:       fb_v = 24'd65535;           // above the 0.85 ceiling
            4:       fb_v = 24'd0;
            default: fb_v = CFG_W'($urandom_range(0, 65535));
        endcase
        case (p)
            0:       mix_v = 24'd65536;
            2:       mix_v = 24'd0;
            5:       mix_v = 24'hFFFFFF;         // masked, then clamped to unity
            default: mix_v = CFG_W'($urandom_range(0, 70000));
        endcase
        case (p)
            1:       step_v = 24'd0;             // zero step acts as one
            3:       step_v = 24'd65536;
            6:       step_v = 24'h1FFFF;
            7:       step_v = 24'd1;
            default: step_v = CFG_W'($urandom_range(1, 8000));
        endcase

        write_reg(CFG_DELAY, dly_v);
        write_reg(CFG_FB, fb_v);
        write_reg(CFG_MIX, mix_v);
        write_reg(CFG_BYPASS, CFG_W'(p % 2));
        write_reg(CFG_STEP, step_v);
        if (p == 4) begin
            // indexes past the register file must not disturb anything
            for (int k = int'(CFG_STEP) + 1; k < (1 << IDX_W); k++) begin
                write_reg(IDX_W'(k), CFG_W'($urandom));
            end
        end
        end_writes();

        for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_dry(random_sample(), random_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_model();
        send_gap_pct = 28;
        recv_stall_pct = 68;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: long delay, taps still empty, ramp starts from zero
        push_dry(24'sd0, 24'sd0);
        push_dry(S_MAX, S_MIN);
        push_dry(S_MIN, S_MAX);
        push_dry(S_MAX, S_MAX);
        push_dry(S_MIN, S_MIN);
        push_dry(24'sd1, -24'sd1);
        push_dry(-24'sd1, 24'sd1);
        push_dry(24'sh555555, 24'shAAAAAA);
        push_dry(24'shAAAAAA, 24'sh555555);
        push_dry(24'sd0, 24'sd0);

        // One sample of delay, maximum cross feedback, fully wet, instant ramp:
        // echoes bounce every sample and the line writes saturate.
        wait_idle();
        write_reg(CFG_DELAY, 24'd256);
        write_reg(CFG_FB, 24'd55705);
        write_reg(CFG_MIX, 24'd65536);
        write_reg(CFG_BYPASS, 24'd0);
        write_reg(CFG_STEP, 24'd65536);
        end_writes();
        push_dry(S_MAX, S_MIN);
        push_dry(S_MAX, S_MIN);
        push_dry(S_MIN, S_MAX);
        push_dry(S_MAX, S_MAX);
        push_dry(S_MIN, S_MIN);
        push_dry(24'sd0, 24'sd0);
        push_dry(24'sd0, 24'sd0);
        push_dry(24'sd0, 24'sd0);
        push_dry(24'sd1, 24'sd0);
        push_dry(24'sd0, 24'sd1);
        push_dry(S_MAX, 24'sd0);
        push_dry(24'sd0, 24'sd0);
        push_dry(24'sd0, 24'sd0);
        push_dry(-24'sd1, -24'sd1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_phase(p);
        end

        // drain, then a tail to catch any stray extra output
        while (accepted_cnt != queued_cnt || expected_out_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
